/* sv/ptd_pkg.sv */
package ptd_pkg;

   localparam int LABEL_W = 5;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_COUNT = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_MARK  = 6'b001000,
      ST_DEC   = 6'b010000,
      ST_LAST  = 6'b100000
   } state_type;

endpackage

/* sv/ptd_ram.sv */
module ptd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/prufer_sequence_tree_decoder.sv */
// Decodes a Pruefer sequence into the edges of its labeled tree. Elements enter one per
// transaction; each element's occurrence count is updated by a read-modify-write of the
// count memory, and busy stays high while it is. The transaction with req_last_element set
// starts the decode, and busy stays high until the last edge has been issued. A sequence
// with a label outside 1..length+2, or with more than MAX_NODES-2 elements, gives a single
// result with rsp_bad_label set, in the cycle after the final element is counted. Otherwise,
// for each sequence entry the count memory is scanned one node per cycle for the lowest free
// leaf, then the leaf is marked and the parent count decremented. The closing edge is found
// by a further scan for the two nodes still free. Each result is shown for one cycle with
// rsp_strobe and cannot be held off, so the receiver must take every strobed transaction.
module prufer_sequence_tree_decoder
   import ptd_pkg::*;
#(
   parameter int MAX_NODES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [LABEL_W-1:0] req_node_label,
   input  logic               req_last_element,
   output logic               rsp_strobe,
   output logic [LABEL_W-1:0] rsp_leaf_node,
   output logic [LABEL_W-1:0] rsp_parent_node,
   output logic               rsp_last_edge,
   output logic               rsp_bad_label
);

   localparam int SEQ_DEPTH = MAX_NODES - 2;
   localparam int SEQ_AW    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int LEN_W     = $clog2(SEQ_DEPTH + 1);
   localparam int NW        = $clog2(MAX_NODES);
   localparam int NCW       = $clog2(MAX_NODES + 1);
   localparam int CW        = $clog2(MAX_NODES - 1);

   function automatic logic [LABEL_W-1:0] node_num(input logic [NW-1:0] idx);
      node_num = LABEL_W'(32'(idx) + 32'd1);
   endfunction

   state_type state_ff, state_in;

   logic [LEN_W-1:0]   len_ff, len_in;
   logic               err_ff, err_in;
   logic               zero_ff, zero_in;
   logic [LABEL_W-1:0] max_ff, max_in;
   logic [MAX_NODES-1:0] vld_ff, vld_in;
   logic               last_ff, last_in;
   logic               cnt_en_ff, cnt_en_in;
   logic [NW-1:0]      lab_addr_ff, lab_addr_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [NCW-1:0]     scan_ff, scan_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [NW-1:0]      chk_idx_ff, chk_idx_in;
   logic               first_ff, first_in;
   logic [LABEL_W-1:0] parent_ff, parent_in;
   logic               leaf_ok_ff, leaf_ok_in;
   logic [NW-1:0]      leaf_idx_ff, leaf_idx_in;
   logic               a_found_ff, a_found_in;
   logic [NW-1:0]      a_idx_ff, a_idx_in;
   logic               cnt_vld_ff, cnt_vld_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [LABEL_W-1:0] rsp_leaf_ff, rsp_leaf_in;
   logic [LABEL_W-1:0] rsp_parent_ff, rsp_parent_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic               cnt_we;
   logic [NW-1:0]      cnt_waddr;
   logic [CW:0]        cnt_wdata;
   logic [NW-1:0]      cnt_raddr;
   logic [CW:0]        cnt_rdata;
   logic [CW-1:0]      rd_cnt;
   logic               rd_rem;
   logic               st_we;
   logic [SEQ_AW-1:0]  st_raddr;
   logic [LABEL_W-1:0] st_rdata;

   logic [NCW-1:0]     n_cur;
   logic [NW-1:0]      n_last_idx;
   logic [NW-1:0]      par_addr;
   logic [LEN_W-1:0]   idx_nx;
   logic               seq_bad;
   logic               slot_free;
   logic               scan_end;
   logic               scan_go;
   logic               clear_seq;

   assign busy       = (state_ff != ST_IDLE);
   assign n_cur      = NCW'(len_ff) + NCW'(2);
   assign n_last_idx = NW'(n_cur - NCW'(1));
   assign par_addr   = NW'(parent_ff - 5'd1);
   assign idx_nx     = idx_ff + 1'b1;
   assign rd_cnt     = cnt_rdata[CW-1:0];
   assign rd_rem     = cnt_rdata[CW];
   assign seq_bad    = err_ff || zero_ff || (8'(max_ff) > 8'(n_cur));
   assign slot_free  = chk_vld_ff && (!cnt_vld_ff || ((rd_cnt == '0) && !rd_rem));
   assign scan_end   = chk_vld_ff && (chk_idx_ff == n_last_idx);
   assign scan_go    = (scan_ff < n_cur);

   always_comb begin
      unique case (state_ff)
         ST_IDLE:           cnt_raddr = NW'(req_node_label - 5'd1);
         ST_SCAN, ST_LAST:  cnt_raddr = scan_go ? scan_ff[NW-1:0] : '0;
         ST_MARK:           cnt_raddr = par_addr;
         default:           cnt_raddr = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      err_in        = err_ff;
      zero_in       = zero_ff;
      max_in        = max_ff;
      vld_in        = vld_ff;
      last_in       = last_ff;
      cnt_en_in     = cnt_en_ff;
      lab_addr_in   = lab_addr_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      first_in      = first_ff;
      parent_in     = parent_ff;
      leaf_ok_in    = leaf_ok_ff;
      leaf_idx_in   = leaf_idx_ff;
      a_found_in    = a_found_ff;
      a_idx_in      = a_idx_ff;
      cnt_vld_in    = vld_ff[cnt_raddr];
      rsp_strobe_in = 1'b0;
      rsp_leaf_in   = rsp_leaf_ff;
      rsp_parent_in = rsp_parent_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = '0;
      cnt_wdata     = '0;
      st_we         = 1'b0;
      st_raddr      = '0;
      clear_seq     = 1'b0;

      if ((state_ff == ST_SCAN) || (state_ff == ST_LAST)) begin
         chk_vld_in = scan_go;
         chk_idx_in = scan_ff[NW-1:0];
         if (scan_go) begin
            scan_in = scan_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               last_in     = req_last_element;
               lab_addr_in = NW'(req_node_label - 5'd1);
               if (len_ff < LEN_W'(SEQ_DEPTH)) begin
                  st_we     = 1'b1;
                  len_in    = len_ff + 1'b1;
                  zero_in   = zero_ff || (req_node_label == '0);
                  max_in    = (req_node_label > max_ff) ? req_node_label : max_ff;
                  cnt_en_in = (req_node_label != '0) &&
                              (32'(req_node_label) <= 32'(MAX_NODES));
               end else begin
                  err_in    = 1'b1;
                  cnt_en_in = 1'b0;
               end
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (cnt_en_ff) begin
               cnt_we    = 1'b1;
               cnt_waddr = lab_addr_ff;
               cnt_wdata = {1'b0, cnt_vld_ff ? rd_cnt + 1'b1 : CW'(1)};
            end
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (seq_bad) begin
               rsp_strobe_in = 1'b1;
               rsp_leaf_in   = '0;
               rsp_parent_in = '0;
               rsp_last_in   = 1'b1;
               rsp_bad_in    = 1'b1;
               clear_seq     = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in   = '0;
               scan_in  = '0;
               first_in = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            first_in = 1'b0;
            if (first_ff) begin
               parent_in = st_rdata;
            end
            if (slot_free || scan_end) begin
               leaf_ok_in    = slot_free;
               leaf_idx_in   = chk_idx_ff;
               rsp_strobe_in = 1'b1;
               rsp_leaf_in   = slot_free ? node_num(chk_idx_ff) : '0;
               rsp_parent_in = parent_ff;
               rsp_last_in   = 1'b0;
               rsp_bad_in    = 1'b0;
               state_in      = ST_MARK;
            end
         end
         ST_MARK: begin
            if (leaf_ok_ff) begin
               cnt_we    = 1'b1;
               cnt_waddr = leaf_idx_ff;
               cnt_wdata = {1'b1, CW'(0)};
            end
            state_in = ST_DEC;
         end
         ST_DEC: begin
            cnt_we     = 1'b1;
            cnt_waddr  = par_addr;
            cnt_wdata  = {cnt_vld_ff && rd_rem,
                          (cnt_vld_ff && (rd_cnt != '0)) ? rd_cnt - 1'b1 : CW'(0)};
            idx_in     = idx_nx;
            st_raddr   = (idx_nx < len_ff) ? idx_nx[SEQ_AW-1:0] : '0;
            scan_in    = '0;
            first_in   = 1'b1;
            a_found_in = 1'b0;
            state_in   = (idx_nx == len_ff) ? ST_LAST : ST_SCAN;
         end
         ST_LAST: begin
            if (slot_free && a_found_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_leaf_in   = node_num(a_idx_ff);
               rsp_parent_in = node_num(chk_idx_ff);
               rsp_last_in   = 1'b1;
               rsp_bad_in    = 1'b0;
               clear_seq     = 1'b1;
               state_in      = ST_IDLE;
            end else if (scan_end) begin
               rsp_strobe_in = 1'b1;
               rsp_leaf_in   = slot_free  ? node_num(chk_idx_ff) :
                               a_found_ff ? node_num(a_idx_ff)   : '0;
               rsp_parent_in = '0;
               rsp_last_in   = 1'b1;
               rsp_bad_in    = 1'b0;
               clear_seq     = 1'b1;
               state_in      = ST_IDLE;
            end else if (slot_free) begin
               a_found_in = 1'b1;
               a_idx_in   = chk_idx_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cnt_we) begin
         vld_in[cnt_waddr] = 1'b1;
      end
      if (clear_seq) begin
         len_in  = '0;
         err_in  = 1'b0;
         zero_in = 1'b0;
         max_in  = '0;
         vld_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         err_ff        <= 1'b0;
         zero_ff       <= 1'b0;
         max_ff        <= '0;
         vld_ff        <= '0;
         last_ff       <= 1'b0;
         cnt_en_ff     <= 1'b0;
         idx_ff        <= '0;
         scan_ff       <= '0;
         chk_vld_ff    <= 1'b0;
         first_ff      <= 1'b0;
         leaf_ok_ff    <= 1'b0;
         a_found_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         err_ff        <= err_in;
         zero_ff       <= zero_in;
         max_ff        <= max_in;
         vld_ff        <= vld_in;
         last_ff       <= last_in;
         cnt_en_ff     <= cnt_en_in;
         idx_ff        <= idx_in;
         scan_ff       <= scan_in;
         chk_vld_ff    <= chk_vld_in;
         first_ff      <= first_in;
         leaf_ok_ff    <= leaf_ok_in;
         a_found_ff    <= a_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lab_addr_ff   <= lab_addr_in;
      chk_idx_ff    <= chk_idx_in;
      parent_ff     <= parent_in;
      leaf_idx_ff   <= leaf_idx_in;
      a_idx_ff      <= a_idx_in;
      cnt_vld_ff    <= cnt_vld_in;
      rsp_leaf_ff   <= rsp_leaf_in;
      rsp_parent_ff <= rsp_parent_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   ptd_ram #(
      .WIDTH (CW + 1),
      .DEPTH (MAX_NODES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   ptd_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (SEQ_DEPTH)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (len_ff[SEQ_AW-1:0]),
      .wr_data (req_node_label),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_leaf_node   = rsp_leaf_ff;
   assign rsp_parent_node = rsp_parent_ff;
   assign rsp_last_edge   = rsp_last_ff;
   assign rsp_bad_label   = rsp_bad_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted element did not make the block busy");

   a_bad_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bad_label) |-> (rsp_last_edge && (rsp_leaf_node == '0)))
      else $error("rejected sequence result is malformed");

   a_dec_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEC) |-> (cnt_vld_ff && (rd_cnt != '0)))
      else $error("parent count exhausted before its decrement");

   a_mark_not_parent: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MARK) && leaf_ok_ff) |-> (leaf_idx_ff != par_addr))
      else $error("leaf chosen equals its parent");

endmodule

/* dv/ptd_checker.sv */
module prufer_decode_checker
   import ptd_pkg::*;
#(
   parameter int MAX_NODES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [LABEL_W-1:0] req_node_label,
   input  logic               req_last_element,
   input  logic               rsp_strobe,
   input  logic [LABEL_W-1:0] rsp_leaf_node,
   input  logic [LABEL_W-1:0] rsp_parent_node,
   input  logic               rsp_last_edge,
   input  logic               rsp_bad_label,
   output int                 fail_count,
   output int                 pending
);

   localparam int SEQ_DEPTH = MAX_NODES - 2;

   typedef struct packed {
      logic [LABEL_W-1:0] leaf;
      logic [LABEL_W-1:0] parent;
      logic               last_edge;
      logic               bad_label;
   } tree_edge_type;

   tree_edge_type      expected_edges[$];
   logic [LABEL_W-1:0] stored_labels[SEQ_DEPTH];
   int                 stored_len = 0;
   bit                 too_long = 1'b0;
   int                 errors = 0;

   function automatic tree_edge_type make_tree_edge(input int leaf, input int parent,
                                                    input bit last_edge, input bit bad_label);
      tree_edge_type e;
      e.leaf      = leaf[LABEL_W-1:0];
      e.parent    = parent[LABEL_W-1:0];
      e.last_edge = last_edge;
      e.bad_label = bad_label;
      return e;
   endfunction

   // Rebuilds the tree from the stored sequence, lowest free leaf first, or predicts one rejection.
   task automatic predict_tree_edges();
      int n;
      bit rejected;
      int occurs[MAX_NODES];
      bit removed[MAX_NODES];
      int leaf;
      int parent;
      int first_free;
      int second_free;
      n        = stored_len + 2;
      rejected = too_long;
      for (int i = 0; i < stored_len; i++) begin
         if (stored_labels[i] < 1 || stored_labels[i] > n) begin
            rejected = 1'b1;
         end
      end
      if (rejected) begin
         expected_edges.push_back(make_tree_edge(0, 0, 1'b1, 1'b1));
         return;
      end
      for (int j = 0; j < MAX_NODES; j++) begin
         occurs[j]  = 0;
         removed[j] = 1'b0;
      end
      for (int i = 0; i < stored_len; i++) begin
         occurs[stored_labels[i] - 1]++;
      end
      for (int i = 0; i < stored_len; i++) begin
         parent = stored_labels[i];
         leaf   = 0;
         for (int j = 0; j < n; j++) begin
            if (leaf == 0 && occurs[j] == 0 && !removed[j]) begin
               leaf = j + 1;
            end
         end
         if (leaf != 0) begin
            removed[leaf - 1] = 1'b1;
         end
         if (occurs[parent - 1] > 0) begin
            occurs[parent - 1]--;
         end
         expected_edges.push_back(make_tree_edge(leaf, parent, 1'b0, 1'b0));
      end
      first_free  = 0;
      second_free = 0;
      for (int j = 0; j < n; j++) begin
         if (occurs[j] == 0 && !removed[j]) begin
            if (first_free == 0) begin
               first_free = j + 1;
            end else if (second_free == 0) begin
               second_free = j + 1;
            end
         end
      end
      expected_edges.push_back(make_tree_edge(first_free, second_free, 1'b1, 1'b0));
   endtask

   task automatic compare_field(input string field_name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
      end
   endtask

   always @(posedge clock) begin
      tree_edge_type want;
      if (reset) begin
         stored_len = 0;
         too_long   = 1'b0;
         expected_edges.delete();
      end else begin
         if (start && !busy) begin
            if (stored_len < SEQ_DEPTH) begin
               stored_labels[stored_len] = req_node_label;
               stored_len++;
            end else begin
               too_long = 1'b1;
            end
            if (req_last_element) begin
               predict_tree_edges();
               stored_len = 0;
               too_long   = 1'b0;
            end
         end
         if (rsp_strobe) begin
            if (expected_edges.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction, expected none, actual leaf %0d parent %0d",
                        $time, rsp_leaf_node, rsp_parent_node);
            end else begin
               want = expected_edges.pop_front();
               compare_field("leaf_node", want.leaf, rsp_leaf_node);
               compare_field("parent_node", want.parent, rsp_parent_node);
               compare_field("last_edge", want.last_edge, rsp_last_edge);
               compare_field("bad_label", want.bad_label, rsp_bad_label);
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_edges.size();
   end

endmodule

/* dv/tb.sv */
module tb;
   import ptd_pkg::*;

   localparam int MAX_NODES   = 16;
   localparam int ITEM_TARGET = 460;
   localparam int QUIET_TAIL  = 60;
   localparam int SEQ_MAX     = 20;
   localparam int SEQ_BITS    = SEQ_MAX * LABEL_W;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [LABEL_W-1:0] req_node_label = '0;
   logic               req_last_element = 1'b0;
   logic               busy;
   logic               rsp_strobe;
   logic [LABEL_W-1:0] rsp_leaf_node;
   logic [LABEL_W-1:0] rsp_parent_node;
   logic               rsp_last_edge;
   logic               rsp_bad_label;
   int                 fail_count;
   int                 pending;
   int                 items_sent = 0;

   prufer_sequence_tree_decoder #(.MAX_NODES(MAX_NODES)) u_top (.*);

   prufer_decode_checker #(.MAX_NODES(MAX_NODES)) u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_element(input logic [LABEL_W-1:0] label, input logic last);
      start            <= 1'b1;
      req_node_label   <= label;
      req_last_element <= last;
      do @(posedge clock); while (busy);
      items_sent++;
      if (items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic play_sequence(input int len, input logic [SEQ_BITS-1:0] labels);
      for (int i = 0; i < len; i++) begin
         send_element(labels[i*LABEL_W +: LABEL_W], i == len - 1);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly valid sequences, with some out-of-range labels and overlong sequences mixed in.
   task automatic random_sequence();
      logic [SEQ_BITS-1:0] labels;
      int kind;
      int len;
      int spot;
      labels = '0;
      kind   = $urandom_range(0, 19);
      if (kind < 15) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
         for (int i = 0; i < len; i++) begin
            labels[i*LABEL_W +: LABEL_W] = LABEL_W'($urandom_range(1, len + 2));
         end
      end else if (kind < 18) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            labels[i*LABEL_W +: LABEL_W] = LABEL_W'($urandom_range(1, len + 2));
         end
         spot = $urandom_range(0, len - 1);
         labels[spot*LABEL_W +: LABEL_W] =
            ($urandom_range(0, 2) == 0) ? '0 : LABEL_W'($urandom_range(len + 3, 31));
      end else begin
         len = (kind == 18) ? $urandom_range(15, 17) : MAX_NODES - 2;
         for (int i = 0; i < len; i++) begin
            labels[i*LABEL_W +: LABEL_W] = LABEL_W'($urandom_range(1, MAX_NODES));
         end
      end
      play_sequence(len, labels);
      if ($urandom_range(0, 24) == 0) begin
         drain_results();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      play_sequence(1, SEQ_BITS'(5'd1));
      play_sequence(1, SEQ_BITS'(5'd3));
      play_sequence(1, SEQ_BITS'(5'd0));
      play_sequence(1, SEQ_BITS'(5'd31));
      play_sequence(1, SEQ_BITS'(5'd4));
      play_sequence(3, SEQ_BITS'({5'd2, 5'd1, 5'd2}));
      play_sequence(3, SEQ_BITS'({5'd1, 5'd1, 5'd1}));
      play_sequence(4, SEQ_BITS'({5'd6, 5'd6, 5'd6, 5'd6}));
      play_sequence(2, SEQ_BITS'({5'd16, 5'd1}));
      drain_results();
      while (items_sent < ITEM_TARGET) begin
         random_sequence();
      end
      drain_results();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
